FILE: hdl/drlp_pkg.sv
package drlp_pkg;

   // parse phases
   localparam logic [3:0] PH_ID      = 4'd0;
   localparam logic [3:0] PH_URL_U   = 4'd1;
   localparam logic [3:0] PH_URL_C   = 4'd2;
   localparam logic [3:0] PH_URL     = 4'd3;
   localparam logic [3:0] PH_TITLE_T = 4'd4;
   localparam logic [3:0] PH_TITLE_C = 4'd5;
   localparam logic [3:0] PH_TITLE   = 4'd6;
   localparam logic [3:0] PH_TEXT_H  = 4'd7;
   localparam logic [3:0] PH_TEXT_C  = 4'd8;
   localparam logic [3:0] PH_TEXT    = 4'd9;
   localparam logic [3:0] PH_DISCARD = 4'd10;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_H     = 8'h48;

   // field tags
   localparam logic [1:0] TAG_NONE  = 2'd0;
   localparam logic [1:0] TAG_URL   = 2'd1;
   localparam logic [1:0] TAG_TITLE = 2'd2;
   localparam logic [1:0] TAG_TEXT  = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_ID   = 3'd1;
   localparam logic [2:0] ERR_ZERO_ID  = 3'd2;
   localparam logic [2:0] ERR_NO_TAB   = 3'd3;
   localparam logic [2:0] ERR_NO_URL   = 3'd4;
   localparam logic [2:0] ERR_NO_TITLE = 3'd5;
   localparam logic [2:0] ERR_NO_TEXT  = 3'd6;

endpackage

FILE: hdl/document_record_line_parser.sv
// channel  | direction | payload
// req_     | in        | char_byte
// rsp_     | out       | data_valid, field_tag, data_byte, record_done, error_code, doc_number
//
// one word in, one word out; a word is decoded in the cycle it is accepted and its
// result shows on rsp_ in the next cycle, so a word can be taken every cycle
// the result register frees up in the cycle it is taken, so outside reset req_ready only
// drops while a result waits and rsp_ready is low
// reset (synchronous, active high) returns the parser to the id phase and empties
// the result register; req_ready is low during reset
module document_record_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_data_valid,
   output logic [1:0]  rsp_field_tag,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_record_done,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_doc_number
);

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [2:0]  err_ff, err_in;

   logic        rsp_valid_ff;
   logic        dv_ff, dv_in;
   logic [1:0]  tag_ff, tag_in;
   logic [7:0]  db_ff, db_in;
   logic        done_ff, done_in;
   logic [2:0]  code_ff, code_in;
   logic [31:0] num_ff, num_in;

   logic        accept;
   logic [7:0]  c;
   logic        is_digit;
   logic [31:0] acc_x10;
   logic [31:0] acc_digit;
   logic        fail;
   logic [2:0]  fail_code;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign c         = req_char_byte;
   assign is_digit  = (c >= drlp_pkg::CH_ZERO) && (c <= drlp_pkg::CH_NINE);
   assign acc_x10   = (acc_ff << 3) + (acc_ff << 1);
   assign acc_digit = acc_x10 + {28'd0, 4'(c - drlp_pkg::CH_ZERO)};

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      fail          = 1'b0;
      fail_code     = drlp_pkg::ERR_NONE;
      dv_in         = 1'b0;
      tag_in        = drlp_pkg::TAG_NONE;
      db_in         = 8'd0;
      num_in        = acc_ff;

      case (phase_ff)
         drlp_pkg::PH_ID: begin
            if (c == drlp_pkg::CH_NUL || c == drlp_pkg::CH_TAB) begin
               if (acc_ff == 32'd0) begin
                  fail      = 1'b1;
                  fail_code = drlp_pkg::ERR_ZERO_ID;
               end else if (c == drlp_pkg::CH_TAB) begin
                  phase_in = drlp_pkg::PH_URL_U;
               end else begin
                  fail      = 1'b1;
                  fail_code = drlp_pkg::ERR_NO_TAB;
               end
            end else if (is_digit) begin
               acc_in = acc_digit;
               num_in = acc_digit;
            end else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_BAD_ID;
            end
         end
         drlp_pkg::PH_URL_U: begin
            if (c == drlp_pkg::CH_U) phase_in = drlp_pkg::PH_URL_C;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_URL;
            end
         end
         drlp_pkg::PH_URL_C: begin
            if (c == drlp_pkg::CH_COLON) phase_in = drlp_pkg::PH_URL;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_URL;
            end
         end
         drlp_pkg::PH_TITLE_T: begin
            if (c == drlp_pkg::CH_T) phase_in = drlp_pkg::PH_TITLE_C;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_TITLE;
            end
         end
         drlp_pkg::PH_TITLE_C: begin
            if (c == drlp_pkg::CH_COLON) phase_in = drlp_pkg::PH_TITLE;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_TITLE;
            end
         end
         drlp_pkg::PH_TEXT_H: begin
            if (c == drlp_pkg::CH_H) phase_in = drlp_pkg::PH_TEXT_C;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_TEXT;
            end
         end
         drlp_pkg::PH_TEXT_C: begin
            if (c == drlp_pkg::CH_COLON) phase_in = drlp_pkg::PH_TEXT;
            else begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_TEXT;
            end
         end
         drlp_pkg::PH_URL, drlp_pkg::PH_TITLE: begin
            if (c == drlp_pkg::CH_TAB) begin
               phase_in = (phase_ff == drlp_pkg::PH_URL) ? drlp_pkg::PH_TITLE_T
                                                          : drlp_pkg::PH_TEXT_H;
            end else if (c == drlp_pkg::CH_NUL) begin
               fail      = 1'b1;
               fail_code = drlp_pkg::ERR_NO_TAB;
            end else begin
               dv_in  = 1'b1;
               tag_in = (phase_ff == drlp_pkg::PH_URL) ? drlp_pkg::TAG_URL
                                                        : drlp_pkg::TAG_TITLE;
               db_in  = c;
            end
         end
         drlp_pkg::PH_TEXT: begin
            // held byte goes out now, except a newline right before the terminator
            if (held_valid_ff &&
                !(c == drlp_pkg::CH_NUL && held_ff == drlp_pkg::CH_NL)) begin
               dv_in  = 1'b1;
               tag_in = drlp_pkg::TAG_TEXT;
               db_in  = held_ff;
            end
            if (c != drlp_pkg::CH_NUL) begin
               held_in       = c;
               held_valid_in = 1'b1;
            end
         end
         default: begin
            // discard phase and unused codes: drop bytes until the terminator
         end
      endcase

      if (fail) begin
         phase_in = drlp_pkg::PH_DISCARD;
         err_in   = fail_code;
      end else begin
         err_in   = err_ff;
      end
      code_in = err_in;
      done_in = (c == drlp_pkg::CH_NUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= drlp_pkg::PH_ID;
         acc_ff        <= 32'd0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         err_ff        <= drlp_pkg::ERR_NONE;
      end else if (accept) begin
         if (done_in) begin
            phase_ff      <= drlp_pkg::PH_ID;
            acc_ff        <= 32'd0;
            held_ff       <= 8'd0;
            held_valid_ff <= 1'b0;
            err_ff        <= drlp_pkg::ERR_NONE;
         end else begin
            phase_ff      <= phase_in;
            acc_ff        <= acc_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            err_ff        <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dv_ff   <= dv_in;
         tag_ff  <= tag_in;
         db_ff   <= db_in;
         done_ff <= done_in;
         code_ff <= code_in;
         num_ff  <= num_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_valid  = dv_ff;
   assign rsp_field_tag   = tag_ff;
   assign rsp_data_byte   = db_ff;
   assign rsp_record_done = done_ff;
   assign rsp_error_code  = code_ff;
   assign rsp_doc_number  = num_ff;

endmodule

FILE: hdl/drlp_checker.sv
module drlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_data_valid,
   input logic [1:0]  rsp_field_tag,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_record_done,
   input logic [2:0]  rsp_error_code,
   input logic [31:0] rsp_doc_number
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_doc_number) && $stable(rsp_error_code))
      else $error("rsp word changed while stalled");

   // a terminator word shows up as record_done in the next cycle
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_char_byte == drlp_pkg::CH_NUL
         |=> rsp_valid && rsp_record_done)
      else $error("terminator did not give record_done");

   // an empty word carries no tag and no byte
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid
         |-> rsp_field_tag == drlp_pkg::TAG_NONE && rsp_data_byte == 8'd0)
      else $error("tag or byte set on an empty word");

   // a field byte is tagged, and never alongside an error
   a_field_tagged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid
         |-> rsp_field_tag != drlp_pkg::TAG_NONE
             && rsp_error_code == drlp_pkg::ERR_NONE)
      else $error("field byte without tag or with error");

endmodule

bind document_record_line_parser drlp_checker u_drlp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_char_byte   (req_char_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_field_tag   (rsp_field_tag),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_record_done (rsp_record_done),
   .rsp_error_code  (rsp_error_code),
   .rsp_doc_number  (rsp_doc_number)
);

FILE: test/document_record_line_parser_test.sv
module document_record_line_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic        data_valid;
      logic [1:0]  field_tag;
      logic [7:0]  data_byte;
      logic        record_done;
      logic [2:0]  error_code;
      logic [31:0] doc_number;
   } field_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_data_valid;
   logic [1:0]  rsp_field_tag;
   logic [7:0]  rsp_data_byte;
   logic        rsp_record_done;
   logic [2:0]  rsp_error_code;
   logic [31:0] rsp_doc_number;

   // parser image kept by the testbench
   logic [3:0]  parser_phase = drlp_pkg::PH_ID;
   logic [31:0] id_value = '0;
   logic [7:0]  text_hold = '0;
   logic        text_hold_vld = 1'b0;
   logic [2:0]  record_err = drlp_pkg::ERR_NONE;

   field_word_type due_words[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          quiet_cycles = 0;
   bit          sender_idle = 1'b0;
   bit          receiver_idle = 1'b0;
   int          rx_hold_cycles = 0;

   document_record_line_parser u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_byte   (req_char_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_field_tag   (rsp_field_tag),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_record_done (rsp_record_done),
      .rsp_error_code  (rsp_error_code),
      .rsp_doc_number  (rsp_doc_number)
   );

   always #5 clock = ~clock;

   function automatic void enter_discard(input logic [2:0] code);
      record_err   = code;
      parser_phase = drlp_pkg::PH_DISCARD;
   endfunction

   function automatic void match_prefix(input logic [7:0] c, input logic [7:0] want,
                                        input logic [3:0] next, input logic [2:0] code);
      if (c == want) parser_phase = next;
      else enter_discard(code);
   endfunction

   // advance the parser image by one byte and queue the word it must produce
   function automatic void parse_char(input logic [7:0] c);
      field_word_type w;
      w = '0;
      w.doc_number = id_value;
      case (parser_phase)
         drlp_pkg::PH_ID: begin
            if (c == drlp_pkg::CH_NUL || c == drlp_pkg::CH_TAB) begin
               if (id_value == 32'd0) enter_discard(drlp_pkg::ERR_ZERO_ID);
               else if (c == drlp_pkg::CH_TAB) parser_phase = drlp_pkg::PH_URL_U;
               else enter_discard(drlp_pkg::ERR_NO_TAB);
            end else if (c >= drlp_pkg::CH_ZERO && c <= drlp_pkg::CH_NINE) begin
               id_value     = id_value * 32'd10 + 32'(c - drlp_pkg::CH_ZERO);
               w.doc_number = id_value;
            end else begin
               enter_discard(drlp_pkg::ERR_BAD_ID);
            end
         end
         drlp_pkg::PH_URL_U:
            match_prefix(c, drlp_pkg::CH_U, drlp_pkg::PH_URL_C, drlp_pkg::ERR_NO_URL);
         drlp_pkg::PH_URL_C:
            match_prefix(c, drlp_pkg::CH_COLON, drlp_pkg::PH_URL, drlp_pkg::ERR_NO_URL);
         drlp_pkg::PH_TITLE_T:
            match_prefix(c, drlp_pkg::CH_T, drlp_pkg::PH_TITLE_C, drlp_pkg::ERR_NO_TITLE);
         drlp_pkg::PH_TITLE_C:
            match_prefix(c, drlp_pkg::CH_COLON, drlp_pkg::PH_TITLE, drlp_pkg::ERR_NO_TITLE);
         drlp_pkg::PH_TEXT_H:
            match_prefix(c, drlp_pkg::CH_H, drlp_pkg::PH_TEXT_C, drlp_pkg::ERR_NO_TEXT);
         drlp_pkg::PH_TEXT_C:
            match_prefix(c, drlp_pkg::CH_COLON, drlp_pkg::PH_TEXT, drlp_pkg::ERR_NO_TEXT);
         drlp_pkg::PH_URL, drlp_pkg::PH_TITLE: begin
            if (c == drlp_pkg::CH_TAB) begin
               parser_phase = (parser_phase == drlp_pkg::PH_URL) ? drlp_pkg::PH_TITLE_T
                                                                 : drlp_pkg::PH_TEXT_H;
            end else if (c == drlp_pkg::CH_NUL) begin
               enter_discard(drlp_pkg::ERR_NO_TAB);
            end else begin
               w.data_valid = 1'b1;
               w.field_tag  = (parser_phase == drlp_pkg::PH_URL) ? drlp_pkg::TAG_URL
                                                                 : drlp_pkg::TAG_TITLE;
               w.data_byte  = c;
            end
         end
         drlp_pkg::PH_TEXT: begin
            // held byte goes out, except a newline right before the terminator
            if (text_hold_vld && !(c == drlp_pkg::CH_NUL && text_hold == drlp_pkg::CH_NL)) begin
               w.data_valid = 1'b1;
               w.field_tag  = drlp_pkg::TAG_TEXT;
               w.data_byte  = text_hold;
            end
            if (c != drlp_pkg::CH_NUL) begin
               text_hold     = c;
               text_hold_vld = 1'b1;
            end
         end
         default: ;
      endcase
      w.error_code = record_err;
      if (c == drlp_pkg::CH_NUL) begin
         w.record_done = 1'b1;
         parser_phase  = drlp_pkg::PH_ID;
         id_value      = '0;
         text_hold     = '0;
         text_hold_vld = 1'b0;
         record_err    = drlp_pkg::ERR_NONE;
      end
      due_words.push_back(w);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) parse_char(req_char_byte);
   end

   task automatic compare_field(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      field_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %0h", $time,
                     {rsp_data_valid, rsp_field_tag, rsp_data_byte, rsp_record_done,
                      rsp_error_code, rsp_doc_number});
            mismatches++;
         end else begin
            w = due_words.pop_front();
            compare_field("data_valid", w.data_valid, rsp_data_valid);
            compare_field("field_tag", w.field_tag, rsp_field_tag);
            compare_field("data_byte", w.data_byte, rsp_data_byte);
            compare_field("record_done", w.record_done, rsp_record_done);
            compare_field("error_code", w.error_code, rsp_error_code);
            compare_field("doc_number", w.doc_number, rsp_doc_number);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("[document_record_line_parser] ERROR");
         $finish;
      end
   end

   // receiver: long hold when asked, else random stall bursts while receiver_idle is set
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic send_word(input logic [7:0] c);
      int gap;
      gap = (sender_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == drlp_pkg::CH_TAB) b = 8'h20;
      return b;
   endfunction

   // one record; a faulty one gets a byte replaced or cut short at a random spot
   task automatic send_record(input bit faulty);
      logic [7:0] rec[$];
      int mode, n, p;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         // pure noise
         repeat ($urandom_range(1, 8)) rec.push_back(8'($urandom_range(1, 255)));
      end else begin
         if (mode == 1) n = $urandom_range(10, 12);       // id wraps
         else if (mode == 2) n = 0;                        // empty id
         else n = $urandom_range(1, 4);
         if (mode == 3) rec.push_back(drlp_pkg::CH_ZERO);  // zero id
         else repeat (n) rec.push_back(drlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
         rec.push_back(drlp_pkg::CH_TAB);
         rec.push_back(drlp_pkg::CH_U);
         rec.push_back(drlp_pkg::CH_COLON);
         repeat ($urandom_range(0, 5)) rec.push_back(plain_byte());
         rec.push_back(drlp_pkg::CH_TAB);
         rec.push_back(drlp_pkg::CH_T);
         rec.push_back(drlp_pkg::CH_COLON);
         repeat ($urandom_range(0, 5)) rec.push_back(plain_byte());
         rec.push_back(drlp_pkg::CH_TAB);
         rec.push_back(drlp_pkg::CH_H);
         rec.push_back(drlp_pkg::CH_COLON);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) rec.push_back(drlp_pkg::CH_NL);
            else rec.push_back(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 1) == 1) rec.push_back(drlp_pkg::CH_NL);
         if (faulty) begin
            p = $urandom_range(0, rec.size() - 1);
            if ($urandom_range(0, 1) == 0) rec[p] = drlp_pkg::CH_NUL;
            else rec[p] = 8'($urandom_range(0, 255));
         end
      end
      rec.push_back(drlp_pkg::CH_NUL);
      foreach (rec[i]) begin
         send_word(rec[i]);
         if (rec[i] == drlp_pkg::CH_NUL) break;
      end
   endtask

   // stop offering the last word before waiting, so it is not taken again
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [7:0] words[] = '{
         // full record with one-byte fields, trailing newline dropped
         8'h39, drlp_pkg::CH_TAB, drlp_pkg::CH_U, drlp_pkg::CH_COLON, 8'h61,
         drlp_pkg::CH_TAB, drlp_pkg::CH_T, drlp_pkg::CH_COLON, 8'h62,
         drlp_pkg::CH_TAB, drlp_pkg::CH_H, drlp_pkg::CH_COLON, 8'h63,
         drlp_pkg::CH_NL, drlp_pkg::CH_NUL,
         drlp_pkg::CH_NUL,                                  // empty id
         8'hFF, drlp_pkg::CH_NUL,                           // high byte in the id
         8'h37, drlp_pkg::CH_NUL,                           // terminator inside the id
         8'h37, drlp_pkg::CH_TAB, 8'h80, drlp_pkg::CH_NUL   // wrong url prefix
      };
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      foreach (words[i]) send_word(words[i]);
   endtask

   task automatic test_random_records();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      while (words_sent < 470) begin
         send_record($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 9) == 0) wait_for_results();
      end
   endtask

   task automatic test_backpressure();
      sender_idle    = 1'b0;
      receiver_idle  = 1'b0;
      rx_hold_cycles = 60;
      send_record(1'b0);
      send_record(1'b0);
   endtask

   task automatic test_drain_pause();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_record(1'b0);
      wait_for_results();
      send_record(1'b1);
   endtask

   task automatic test_steady_stream();
      int start;
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      start = words_sent;
      while (words_sent < start + 60) send_record($urandom_range(0, 3) == 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_records();
      test_backpressure();
      test_drain_pause();
      test_steady_stream();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && due_words.size() == 0) begin
         $display("[document_record_line_parser] OK");
      end else begin
         $display("[document_record_line_parser] ERROR");
      end
      $finish;
   end

endmodule
